FILE: rtl/irst_pkg.sv
// Shared types and constants for the ignition rpm and spark timer.
package irst_pkg;

   localparam int KIND_W  = 2;
   localparam int DELAY_W = 20;
   localparam int PPR_W   = 8;
   localparam int RPM_W   = 16;
   localparam int NUM_W   = 26;

   localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_IGNITION = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SPEED    = 2'd2;

   localparam logic [NUM_W-1:0]   US_PER_MINUTE  = 26'd60000000;
   localparam logic [31:0]        MIN_RPM_PERIOD = 32'd1000;
   localparam logic [DELAY_W-1:0] MIN_DELAY      = 20'd100;
   localparam logic [PPR_W-1:0]   PPR_RESET      = 8'd1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: rtl/ignition_rpm_and_spark_timer_core.sv
// Top level: time base, pulse period capture, spark timer and rpm sequencer.
//
// Requests arrive on req_valid/req_ready with req_kind (tick, ignition edge,
// speed edge) and req_fire_delay_us. Every request produces exactly one
// response on rsp_valid/rsp_ready carrying the spark level, both measured
// periods and the current rpm.
// Ticks, speed edges, unused kinds and ignition edges that start no divide
// (first edge, period not above MIN_RPM_PERIOD, or pulses_per_rev of 0) go
// to the output state, which registers their response and then returns to
// idle for the next request. An ignition edge that updates rpm by division
// takes these steps: one multiply of period by pulses_per_rev, the divider
// start, one quotient bit per cycle, then the rpm update and the output
// state. req_ready is high only while the sequencer is idle.
// The response register holds one result; a new request may be accepted
// while it waits, but that request's response is held back until the
// receiver takes the earlier one, and the block stays busy meanwhile.
// csr_wr_en/csr_wr_data write pulses_per_rev; write it only while idle.
// Synchronous reset clears all timing state, drops rsp_valid and sets
// pulses_per_rev to 1.
module ignition_rpm_and_spark_timer_core
   import irst_pkg::*;
#(
   parameter int SPARK_WIDTH_TICKS = 50,
   parameter int TIME_WIDTH        = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [DELAY_W-1:0]    req_fire_delay_us,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_spark_out,
   output logic [TIME_WIDTH-1:0] rsp_ignition_period_us,
   output logic [RPM_W-1:0]      rsp_rpm,
   output logic [TIME_WIDTH-1:0] rsp_speed_period_us,
   input  logic                  csr_wr_en,
   input  logic [PPR_W-1:0]      csr_wr_data
);

   localparam int TW  = TIME_WIDTH;
   localparam int DVW = TIME_WIDTH + PPR_W;
   localparam int SPW = $clog2(SPARK_WIDTH_TICKS + 1);
   localparam logic [SPW-1:0] SPARK_LOAD = SPW'(SPARK_WIDTH_TICKS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MUL   = 5'b00010,
      ST_START = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [TW-1:0]    time_now_ff, time_now_in;
   logic [TW-1:0]    ign_last_ff, ign_last_in;
   logic             ign_seen_ff, ign_seen_in;
   logic [TW-1:0]    ign_period_ff, ign_period_in;
   logic [RPM_W-1:0] rpm_ff, rpm_in;
   logic [TW-1:0]    spd_last_ff, spd_last_in;
   logic             spd_seen_ff, spd_seen_in;
   logic [TW-1:0]    spd_period_ff, spd_period_in;
   logic [DELAY_W-1:0] delay_left_ff, delay_left_in;
   logic             armed_ff, armed_in;
   logic [SPW-1:0]   spark_left_ff, spark_left_in;
   logic [PPR_W-1:0] ppr_ff, ppr_in;
   logic [DVW-1:0]   prod_ff, prod_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_spark_ff;
   logic [TW-1:0]    rsp_ign_ff;
   logic [RPM_W-1:0] rsp_rpm_ff;
   logic [TW-1:0]    rsp_spd_ff;

   logic               accept;
   logic               out_free;
   logic [TW-1:0]      ign_diff;
   logic [DELAY_W-1:0] delay_dec;
   logic               div_start;
   div_status_type     div_status;
   logic [NUM_W-1:0]   div_quot;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ign_diff = time_now_ff - ign_last_ff;

   always_comb begin
      state_in      = state_ff;
      time_now_in   = time_now_ff;
      ign_last_in   = ign_last_ff;
      ign_seen_in   = ign_seen_ff;
      ign_period_in = ign_period_ff;
      rpm_in        = rpm_ff;
      spd_last_in   = spd_last_ff;
      spd_seen_in   = spd_seen_ff;
      spd_period_in = spd_period_ff;
      delay_left_in = delay_left_ff;
      armed_in      = armed_ff;
      spark_left_in = spark_left_ff;
      ppr_in        = csr_wr_en ? csr_wr_data : ppr_ff;
      prod_in       = prod_ff;
      div_start     = 1'b0;
      delay_dec     = (delay_left_ff != '0) ? delay_left_ff - 1'b1 : delay_left_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_OUT;
               case (req_kind)
                  KIND_TICK: begin
                     time_now_in = time_now_ff + 1'b1;
                     if (spark_left_ff != '0) begin
                        spark_left_in = spark_left_ff - 1'b1;
                     end
                     if (armed_ff) begin
                        delay_left_in = delay_dec;
                        if (delay_dec == '0) begin
                           armed_in      = 1'b0;
                           spark_left_in = SPARK_LOAD;
                        end
                     end
                  end
                  KIND_IGNITION: begin
                     if (ign_seen_ff) begin
                        ign_period_in = ign_diff;
                        if (32'(ign_diff) > MIN_RPM_PERIOD) begin
                           if (ppr_ff != '0) begin
                              state_in = ST_MUL;
                           end else begin
                              rpm_in = '0;
                           end
                        end
                        if (req_fire_delay_us > MIN_DELAY &&
                            32'(req_fire_delay_us) < 32'(ign_diff)) begin
                           delay_left_in = req_fire_delay_us;
                           armed_in      = 1'b1;
                        end
                     end
                     ign_last_in = time_now_ff;
                     ign_seen_in = 1'b1;
                  end
                  KIND_SPEED: begin
                     if (spd_seen_ff) begin
                        spd_period_in = time_now_ff - spd_last_ff;
                     end
                     spd_last_in = time_now_ff;
                     spd_seen_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = DVW'(ign_period_ff) * DVW'(ppr_ff);
            state_in = ST_START;
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               rpm_in   = div_quot[RPM_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_now_ff   <= '0;
         ign_last_ff   <= '0;
         ign_seen_ff   <= 1'b0;
         ign_period_ff <= '0;
         rpm_ff        <= '0;
         spd_last_ff   <= '0;
         spd_seen_ff   <= 1'b0;
         spd_period_ff <= '0;
         delay_left_ff <= '0;
         armed_ff      <= 1'b0;
         spark_left_ff <= '0;
         ppr_ff        <= PPR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         time_now_ff   <= time_now_in;
         ign_last_ff   <= ign_last_in;
         ign_seen_ff   <= ign_seen_in;
         ign_period_ff <= ign_period_in;
         rpm_ff        <= rpm_in;
         spd_last_ff   <= spd_last_in;
         spd_seen_ff   <= spd_seen_in;
         spd_period_ff <= spd_period_in;
         delay_left_ff <= delay_left_in;
         armed_ff      <= armed_in;
         spark_left_ff <= spark_left_in;
         ppr_ff        <= ppr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      prod_ff <= prod_in;
      if (state_ff == ST_OUT && out_free) begin
         rsp_spark_ff <= (spark_left_ff != '0);
         rsp_ign_ff   <= ign_period_ff;
         rsp_rpm_ff   <= rpm_ff;
         rsp_spd_ff   <= spd_period_ff;
      end
   end

   irst_div #(
      .DVW(DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (prod_ff),
      .status   (div_status),
      .quotient (div_quot)
   );

   assign req_ready              = (state_ff == ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_spark_out          = rsp_spark_ff;
   assign rsp_ignition_period_us = rsp_ign_ff;
   assign rsp_rpm                = rsp_rpm_ff;
   assign rsp_speed_period_us    = rsp_spd_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("accepted a request without leaving idle");

   a_div_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ST_DIV)
      else $error("divider running outside the divide state");

   a_armed_has_delay: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> delay_left_ff != '0)
      else $error("timer armed with zero delay left");

   a_spark_bounded: assert property (@(posedge clock) disable iff (reset)
      spark_left_ff <= SPARK_LOAD)
      else $error("spark counter beyond pulse width");

   a_out_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("response not registered when leaving output state");

endmodule

FILE: rtl/irst_div.sv
// Restoring divider: US_PER_MINUTE divided by a registered divisor, one bit per cycle.
module irst_div
   import irst_pkg::*;
#(
   parameter int DVW = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVW-1:0]   divisor,
   output div_status_type   status,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DVW-1:0]   dvs_ff, dvs_in;
   logic [DVW-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;

   logic [DVW:0]     trial;
   logic [DVW-1:0]   diff;
   logic             qbit;

   always_comb begin
      trial    = {rem_ff, quot_ff[NUM_W-1]};
      diff     = trial[DVW-1:0] - dvs_ff;
      qbit     = (trial >= {1'b0, dvs_ff});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvs_in   = divisor;
         rem_in   = '0;
         quot_in  = US_PER_MINUTE;
      end else if (busy_ff) begin
         rem_in   = qbit ? diff : trial[DVW-1:0];
         quot_in  = {quot_ff[NUM_W-2:0], qbit};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule
